// File: design/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, status codes and defaults of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Default pool size in units.
    localparam int POOL_SIZE_DEFAULT = 1024;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_BADSIZE = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    // Request kinds.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [10:0] request_size;
        logic [9:0]  block_offset;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] granted_offset;
        logic [3:0] granted_order;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       clr_wr;
        logic       load;
        logic       rd_off;
        logic       rd_bud;
        logic       walk_step;
        logic       split_init;
        logic       split_wr;
        logic       alloc_wr;
        logic       free_wr;
        logic       merge_high;
        logic       merge_low;
        logic       res_set;
        logic [1:0] res_code;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic is_free_req;
        logic bad_size;
        logic bad_off;
        logic fit;
        logic walk_end;
        logic split_more;
        logic free_ok;
        logic can_merge;
        logic bud_ok;
        logic out_free;
    } t_sts;

endpackage

// File: design/bba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the allocator: clearing pass, block walk, split and merge.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_DISP  = 13'b0000000000100,
        S_AREAD = 13'b0000000001000,
        S_ACHK  = 13'b0000000010000,
        S_SPLIT = 13'b0000000100000,
        S_FREAD = 13'b0000001000000,
        S_FCHK  = 13'b0000010000000,
        S_MTEST = 13'b0000100000000,
        S_MCHK  = 13'b0001000000000,
        S_MHIGH = 13'b0010000000000,
        S_MLOW  = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_code, n_code;

    assign o_in_stall = (r_state != S_IDLE);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.is_free_req) begin
                    if (i_sts.bad_off) begin
                        n_code  = ST_BADFREE;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FREAD;
                    end
                end else if (i_sts.bad_size) begin
                    n_code  = ST_BADSIZE;
                    n_state = S_DONE;
                end else begin
                    n_state = S_AREAD;
                end
            end
            S_AREAD: begin
                o_cmd.rd_off = 1'b1;
                n_state      = S_ACHK;
            end
            S_ACHK: begin
                if (i_sts.fit) begin
                    o_cmd.split_init = 1'b1;
                    n_state          = S_SPLIT;
                end else if (i_sts.walk_end) begin
                    n_code  = ST_NOFIT;
                    n_state = S_DONE;
                end else begin
                    o_cmd.walk_step = 1'b1;
                    n_state         = S_AREAD;
                end
            end
            S_SPLIT: begin
                if (i_sts.split_more) begin
                    o_cmd.split_wr = 1'b1;
                end else begin
                    o_cmd.alloc_wr = 1'b1;
                    n_code         = ST_OK;
                    n_state        = S_DONE;
                end
            end
            S_FREAD: begin
                o_cmd.rd_off = 1'b1;
                n_state      = S_FCHK;
            end
            S_FCHK: begin
                if (i_sts.free_ok) begin
                    o_cmd.free_wr = 1'b1;
                    n_state       = S_MTEST;
                end else begin
                    n_code  = ST_BADFREE;
                    n_state = S_DONE;
                end
            end
            S_MTEST: begin
                if (i_sts.can_merge) begin
                    o_cmd.rd_bud = 1'b1;
                    n_state      = S_MCHK;
                end else begin
                    n_code  = ST_OK;
                    n_state = S_DONE;
                end
            end
            S_MCHK: begin
                if (i_sts.bud_ok) begin
                    n_state = S_MHIGH;
                end else begin
                    n_code  = ST_OK;
                    n_state = S_DONE;
                end
            end
            S_MHIGH: begin
                o_cmd.merge_high = 1'b1;
                n_state          = S_MLOW;
            end
            S_MLOW: begin
                o_cmd.merge_low = 1'b1;
                n_state         = S_MTEST;
            end
            S_DONE: begin
                // Hand the result over once the output register is free.
                o_cmd.res_code = r_code;
                if (i_sts.out_free) begin
                    o_cmd.res_set = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// File: design/bba_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_dpath
// Block table memory, working registers and the output register.
// ----------------------------------------------------------------------------
module bba_dpath import bba_pkg::*; #(
    parameter int POOL_SIZE = POOL_SIZE_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    localparam int TOP_ORDER = $clog2(POOL_SIZE + 1) - 1;
    localparam int AW        = TOP_ORDER;
    localparam int SPAN      = 1 << TOP_ORDER;
    localparam int OW        = $clog2(TOP_ORDER + 1);
    localparam int LW        = ((AW > 10) ? AW : 10) + 1;
    localparam int CW        = ((AW + 1) > 11) ? (AW + 1) : 11;
    localparam int EW        = OW + 2;

    // Memory word: start mark, free mark, order.
    logic [EW-1:0] r_mem [SPAN];

    logic          r_kind;
    logic [CW-1:0] r_req;
    logic [LW-1:0] r_off;
    logic [OW-1:0] r_k;
    logic [AW-1:0] r_clr;
    logic          r_e_start, r_e_free;
    logic [OW-1:0] r_e_ord;
    logic          r_out_valid;
    t_out_item     r_out;

    logic [AW-1:0] off_a, bud_a, low_a, high_a, upper_a, rd_a, wr_a;
    logic [OW-1:0] ord_c, k_dec;
    logic [CW-1:0] blk_size, half_size;
    logic [LW-1:0] next_off;
    logic          rd_en, wr_en;
    logic [EW-1:0] wr_d;
    logic [OW+3:0] ord_ext;
    logic [AW+9:0] off_ext;

    assign off_a   = r_off[AW-1:0];
    assign bud_a   = off_a ^ (AW'(1) << r_k);
    assign low_a   = off_a & ~(AW'(1) << r_k);
    assign high_a  = off_a | (AW'(1) << r_k);
    assign k_dec   = r_k - OW'(1);
    assign upper_a = off_a | (AW'(1) << k_dec);

    // Stored order, clamped to the top order.
    assign ord_c     = (r_e_ord > OW'(TOP_ORDER)) ? OW'(TOP_ORDER) : r_e_ord;
    assign blk_size  = CW'(1) << ord_c;
    assign half_size = CW'(1) << k_dec;
    assign next_off  = r_off + (LW'(1) << ord_c);

    // Status towards the controller.
    always_comb begin
        o_sts.clr_last    = (r_clr == {AW{1'b1}});
        o_sts.is_free_req = (r_kind == KIND_FREE);
        o_sts.bad_size    = (r_req == '0) || (r_req > CW'(SPAN));
        o_sts.bad_off     = (r_off >= LW'(SPAN));
        o_sts.fit         = r_e_start && r_e_free && (blk_size >= r_req);
        o_sts.walk_end    = (next_off >= LW'(SPAN));
        o_sts.split_more  = (r_k != '0) && (r_req <= half_size);
        o_sts.free_ok     = r_e_start && !r_e_free;
        o_sts.can_merge   = (r_k < OW'(TOP_ORDER));
        o_sts.bud_ok      = r_e_start && r_e_free && (r_e_ord == r_k);
        o_sts.out_free    = !r_out_valid || !i_out_stall;
    end

    // Memory port selection.
    always_comb begin
        rd_en = i_cmd.rd_off || i_cmd.rd_bud;
        rd_a  = i_cmd.rd_bud ? bud_a : off_a;
        wr_en = 1'b1;
        wr_a  = off_a;
        wr_d  = {1'b1, 1'b1, r_e_ord};
        if (i_cmd.clr_wr) begin
            wr_a = r_clr;
            wr_d = (r_clr == '0) ? {1'b1, 1'b1, OW'(TOP_ORDER)} : {1'b0, 1'b1, OW'(0)};
        end else if (i_cmd.split_wr) begin
            wr_a = upper_a;
            wr_d = {1'b1, 1'b1, k_dec};
        end else if (i_cmd.alloc_wr) begin
            wr_d = {1'b1, 1'b0, r_k};
        end else if (i_cmd.free_wr) begin
            wr_d = {1'b1, 1'b1, r_e_ord};
        end else if (i_cmd.merge_high) begin
            wr_a = high_a;
            wr_d = {1'b0, 1'b1, OW'(0)};
        end else if (i_cmd.merge_low) begin
            wr_a = low_a;
            wr_d = {1'b1, 1'b1, r_k + OW'(1)};
        end else begin
            wr_en = 1'b0;
        end
    end

    // Block table memory with registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_a] <= wr_d;
        if (rd_en) {r_e_start, r_e_free, r_e_ord} <= r_mem[rd_a];
    end

    // Clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_in_data.kind;
            r_req  <= CW'(i_in_data.request_size);
            r_off  <= (i_in_data.kind == KIND_FREE) ? LW'(i_in_data.block_offset) : '0;
        end else if (i_cmd.walk_step) begin
            r_off <= next_off;
        end else if (i_cmd.merge_low) begin
            r_off <= LW'(low_a);
        end
        if (i_cmd.split_init || i_cmd.free_wr) begin
            r_k <= ord_c;
        end else if (i_cmd.split_wr) begin
            r_k <= k_dec;
        end else if (i_cmd.merge_low) begin
            r_k <= r_k + OW'(1);
        end
    end

    // Output register.
    assign ord_ext = {4'b0, r_k};
    assign off_ext = {10'b0, off_a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_set) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_out.status <= i_cmd.res_code;
            if (i_cmd.res_code == ST_OK && r_kind == KIND_ALLOC) begin
                r_out.granted_offset <= off_ext[9:0];
                r_out.granted_order  <= ord_ext[3:0];
            end else begin
                r_out.granted_offset <= '0;
                r_out.granted_order  <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: design/buddy_block_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Binary buddy allocator: allocate and free requests, one result per item.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on i_in_valid / o_in_stall with i_in_data; results leave on
// o_out_valid / i_out_stall with o_out_data. An item moves at a clock edge
// where valid is high and stall is low.
// One request is handled at a time through a block table memory with one
// read port, one write port and a registered read.
// Allocate: the blocks are visited in address order and the first free block
// that fits is halved as far as the size allows; a bad size answers with
// ST_BADSIZE and a request with no fitting block with ST_NOFIT.
// Free: the block is marked free and merged with a free buddy of equal order,
// level by level up to the top order; an offset outside the pool or one that
// is not an allocated block start answers with ST_BADFREE.
// The input stall drops as the result is registered. While the receiver
// stalls, one further request is still taken and worked; its hand-over
// waits, and the input stays stalled until the output is free.
// After reset the table is cleared by a pass of one entry per cycle over the
// managed pool (the largest power of two not above POOL_SIZE, 1024 entries by
// default); o_in_stall stays high during that pass.
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit import bba_pkg::*; #(
    parameter int POOL_SIZE = POOL_SIZE_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Table and working registers.
    bba_dpath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// File: sim/buddy_block_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit_tb
// Checks the buddy allocator against a behavioural model of the pool kept in
// the testbench. Requests are sent through one shared task, every result is
// compared field by field with the oldest prediction, and both sides idle in
// random bursts.
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit_tb;
    import bba_pkg::*;

    localparam int POOL = POOL_SIZE_DEFAULT;
    localparam int TOP = 10;
    localparam int SPAN = 1 << TOP;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    buddy_block_allocator_unit #(.POOL_SIZE(POOL)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_data(o_out_data)
    );

    // Shadow copy of the pool.
    logic [3:0] pool_order [SPAN];
    bit         pool_start [SPAN];
    bit         pool_free  [SPAN];

    t_out_item  grant_queue[$];
    int         live_blocks[$];
    int         error_count;
    int         idle_cycles;
    bit         calm;
    bit         hold_rx;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Allocation as the pool would do it.
    function automatic t_out_item pool_alloc(int req);
        t_out_item r;
        int off;
        int k;
        bit found;
        r = '0;
        off = 0;
        found = 0;
        if (req == 0 || req > SPAN) begin
            r.status = ST_BADSIZE;
            return r;
        end
        while (off < SPAN) begin
            k = (pool_order[off] > TOP) ? TOP : pool_order[off];
            if (pool_start[off] && pool_free[off] && (1 << k) >= req) begin
                found = 1;
                break;
            end
            off += 1 << k;
        end
        if (!found) begin
            r.status = ST_NOFIT;
            return r;
        end
        k = pool_order[off];
        while (k > 0 && req <= (1 << (k - 1))) begin
            k--;
            pool_start[off + (1 << k)] = 1;
            pool_free[off + (1 << k)] = 1;
            pool_order[off + (1 << k)] = k[3:0];
        end
        pool_order[off] = k[3:0];
        pool_free[off] = 0;
        r.status = ST_OK;
        r.granted_offset = off[9:0];
        r.granted_order = k[3:0];
        return r;
    endfunction

    // Release and merge with free buddies of equal size.
    function automatic t_out_item pool_release(int off);
        t_out_item r;
        int k;
        int bud;
        int lo;
        int hi;
        r = '0;
        if (off >= SPAN || !pool_start[off] || pool_free[off]) begin
            r.status = ST_BADFREE;
            return r;
        end
        pool_free[off] = 1;
        k = pool_order[off];
        while (k < TOP) begin
            bud = off ^ (1 << k);
            if (!pool_start[bud] || !pool_free[bud] || pool_order[bud] != k) break;
            lo = (off < bud) ? off : bud;
            hi = (off < bud) ? bud : off;
            pool_start[hi] = 0;
            pool_free[hi] = 1;
            pool_order[hi] = 0;
            k++;
            pool_order[lo] = k[3:0];
            pool_free[lo] = 1;
            off = lo;
        end
        r.status = ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("error: %s got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Sends one request and records its prediction; keeps the list of live
    // blocks so that frees can be aimed at them. Valid stays high after the
    // item is taken and is dropped when an idle gap or a drain follows.
    task automatic send_request(logic kind, int size, int off);
        t_in_item it;
        t_out_item r;
        int gap;
        int i;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.kind = kind;
        it.request_size = size[10:0];
        it.block_offset = off[9:0];
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (kind == KIND_ALLOC) begin
            r = pool_alloc(it.request_size);
            if (r.status == ST_OK) live_blocks = {live_blocks, int'(r.granted_offset)};
        end else begin
            r = pool_release(it.block_offset);
            if (r.status == ST_OK)
                for (i = 0; i < live_blocks.size(); i++)
                    if (live_blocks[i] == it.block_offset) begin
                        live_blocks.delete(i);
                        break;
                    end
        end
        grant_queue = {grant_queue, r};
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (grant_queue.size() != 0) @(posedge i_clk);
    endtask

    // Small sizes are most common so the pool fragments deeply.
    function automatic int pick_size();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 2047);
            1, 2: return $urandom_range(1, 1024);
            3: return 1 << $urandom_range(0, 10);
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    task automatic send_random(int count);
        int n;
        int idx;
        for (n = 0; n < count; n++) begin
            if (live_blocks.size() != 0 && $urandom_range(0, 9) < 5) begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                send_request(KIND_FREE, $urandom_range(0, 2047), live_blocks[idx]);
            end else if ($urandom_range(0, 9) == 0) begin
                send_request(KIND_FREE, $urandom_range(0, 2047), $urandom_range(0, 1023));
            end else begin
                send_request(KIND_ALLOC, pick_size(), $urandom_range(0, 1023));
            end
        end
    endtask

    // Directed edges: bad sizes, whole pool, no fit, bad frees, deep merge.
    task automatic test_directed();
        send_request(KIND_ALLOC, 0, 1023);
        send_request(KIND_ALLOC, 1025, 0);
        send_request(KIND_ALLOC, 2047, 0);
        send_request(KIND_FREE, 0, 0);
        send_request(KIND_ALLOC, 1024, 0);
        send_request(KIND_ALLOC, 1, 0);
        send_request(KIND_FREE, 2047, 0);
        send_request(KIND_FREE, 0, 0);
        send_request(KIND_ALLOC, 1, 1023);
        send_request(KIND_ALLOC, 1, 0);
        send_request(KIND_ALLOC, 3, 0);
        send_request(KIND_ALLOC, 513, 0);
        send_request(KIND_ALLOC, 512, 0);
        send_request(KIND_FREE, 0, 1);
        send_request(KIND_FREE, 0, 1023);
        send_request(KIND_FREE, 0, 0);
        send_request(KIND_FREE, 0, 1);
        send_request(KIND_FREE, 0, 4);
        send_request(KIND_FREE, 0, 512);
        send_request(KIND_ALLOC, 1024, 0);
        send_request(KIND_FREE, 0, 0);
        wait_drained();
    endtask

    // Receiver holds off long while the sender keeps going; the receiver
    // process ends the hold by itself.
    task automatic test_backpressure();
        hold_rx = 1'b1;
        send_random(40);
        wait_drained();
    endtask

    task automatic test_random();
        send_random(1100);
        wait_drained();
        calm = 1'b1;
        send_random(150);
        wait_drained();
    endtask

    // Receiver stall bursts, or one long counted hold on request.
    initial begin
        int burst;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_rx) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 9);
                i_out_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // Result checker and idle watchdog.
    initial begin
        t_out_item want;
        error_count = 0;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                if (grant_queue.size() == 0) begin
                    report_mismatch("unexpected result status", o_out_data.status, -1);
                end else begin
                    want = grant_queue.pop_front();
                    if (o_out_data.status != want.status)
                        report_mismatch("status", o_out_data.status, want.status);
                    if (o_out_data.granted_offset != want.granted_offset)
                        report_mismatch("granted_offset", o_out_data.granted_offset,
                                        want.granted_offset);
                    if (o_out_data.granted_order != want.granted_order)
                        report_mismatch("granted_order", o_out_data.granted_order,
                                        want.granted_order);
                end
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall) || hold_rx)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("buddy_block_allocator_unit: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int p;
        calm = 1'b0;
        hold_rx = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        for (p = 0; p < SPAN; p++) begin
            pool_order[p] = 0;
            pool_start[p] = 0;
            pool_free[p] = 1;
        end
        pool_order[0] = TOP[3:0];
        pool_start[0] = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && grant_queue.size() == 0)
            $display("buddy_block_allocator_unit: match");
        else
            $display("buddy_block_allocator_unit: mismatch");
        $finish;
    end

endmodule
